[rtl/core/puwc_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the periodic unwrap / weighted centre block
// no dependencies
package puwc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 8;

	// divisor used when total_weight is zero
	localparam logic signed [31:0] WEIGHT_ONE = 32'(1) << FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X        = CFG_IDX_W'(0),
		REG_BOX_Y        = CFG_IDX_W'(1),
		REG_BOX_Z        = CFG_IDX_W'(2),
		REG_TOTAL_WEIGHT = CFG_IDX_W'(3)
	} puwc_reg_t;

	typedef struct packed {
		logic [30:0] box_x;
		logic [30:0] box_y;
		logic [30:0] box_z;
	} puwc_box_t;

	// one unwrapped atom waiting for accumulation
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] w;
		logic               last;
		logic               err;
	} puwc_atom_t;

endpackage

[rtl/core/puwc_front.sv]
`timescale 1ns / 1ps
// input side: takes atom beats, tracks the reference atom and unwraps each axis
// depends on puwc_pkg, feeds puwc_fifo
module puwc_front import puwc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  puwc_box_t    box,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // atom_x, atom_y, atom_z, atom_weight
	input  logic         s_axis_tlast,  // last_atom
	input  logic         fifo_full,
	output logic         push,
	output puwc_atom_t   push_data
);

	typedef struct packed {
		logic signed [31:0] p;
		logic               err;
	} unwrap_t;

	localparam logic signed [35:0] P_MAX = 36'sd2147483647;
	localparam logic signed [35:0] P_MIN = -36'sd2147483648;

	function automatic unwrap_t unwrap_axis(input logic signed [31:0] pos,
			input logic signed [32:0] d, input logic [30:0] bx);
		logic signed [35:0] b;
		logic signed [35:0] b3;
		logic signed [35:0] d2;
		logic signed [35:0] p;
		unwrap_t            r;
		b     = $signed({5'd0, bx});
		b3    = b + (b <<< 1);
		d2    = $signed({{2{d[32]}}, d, 1'b0});
		p     = $signed({{4{pos[31]}}, pos});
		r.err = 1'b0;
		if (d2 > b) begin
			p     = p - b;
			r.err = d2 > b3;
		end else if (d2 < -b) begin
			p     = p + b;
			r.err = d2 < -b3;
		end
		if (p > P_MAX) begin
			r.p   = P_MAX[31:0];
			r.err = 1'b1;
		end else if (p < P_MIN) begin
			r.p   = P_MIN[31:0];
			r.err = 1'b1;
		end else begin
			r.p = p[31:0];
		end
		return r;
	endfunction

	logic signed [31:0] pos_in  [3];
	logic signed [31:0] ref_sel [3];
	logic signed [32:0] d_in    [3];
	logic [30:0]        box_a   [3];
	logic signed [31:0] ref_q   [3];
	logic               at_start_q;

	logic               valid_s1;
	logic signed [31:0] pos_s1  [3];
	logic signed [32:0] d_s1    [3];
	logic signed [31:0] w_s1;
	logic               last_s1;
	unwrap_t            uw      [3];
	logic               accept;

	assign box_a[0] = box.box_x;
	assign box_a[1] = box.box_y;
	assign box_a[2] = box.box_z;

	assign s_axis_tready = !valid_s1 || !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = valid_s1 && !fifo_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_in[i]  = $signed(s_axis_tdata[32*i +: 32]);
			ref_sel[i] = at_start_q ? pos_in[i] : ref_q[i];
			d_in[i]    = $signed({pos_in[i][31], pos_in[i]})
				- $signed({ref_sel[i][31], ref_sel[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			valid_s1   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ref_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				valid_s1   <= 1'b1;
				at_start_q <= s_axis_tlast;
				if (at_start_q) begin
					for (int i = 0; i < 3; i++) begin
						ref_q[i] <= pos_in[i];
					end
				end
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pos_in[i];
				d_s1[i]   <= d_in[i];
			end
			w_s1    <= $signed(s_axis_tdata[127:96]);
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uw[i] = unwrap_axis(pos_s1[i], d_s1[i], box_a[i]);
		end
		push_data.px   = uw[0].p;
		push_data.py   = uw[1].p;
		push_data.pz   = uw[2].p;
		push_data.w    = w_s1;
		push_data.last = last_s1;
		push_data.err  = uw[0].err | uw[1].err | uw[2].err;
	end

endmodule

[rtl/core/puwc_fifo.sv]
`timescale 1ns / 1ps
// short queue of unwrapped atoms between the front and back sides
// depends on puwc_pkg
module puwc_fifo import puwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  puwc_atom_t push_data,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output puwc_atom_t head
);

	puwc_atom_t           mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign full      = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("queue pushed while full");

endmodule

[rtl/core/puwc_div.sv]
`timescale 1ns / 1ps
// signed 64 by 32 divider, one quotient bit per cycle, result clamped to 32 bits
// depends on puwc_pkg
module puwc_div import puwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quot,
	output logic               sat
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIN  = 3'b100
	} div_state_t;

	div_state_t  state_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        qbit;

	assign trial = {rem_q, num_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = trial >= {1'b0, den_q};
	assign done  = state_q == D_FIN;

	always_comb begin
		if (neg_q) begin
			sat  = num_q > 64'h0000_0000_8000_0000;
			quot = sat ? 32'sh8000_0000 : $signed(-num_q[31:0]);
		end else begin
			sat  = num_q > 64'h0000_0000_7FFF_FFFF;
			quot = sat ? 32'sh7FFF_FFFF : $signed(num_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= '0;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			neg_q <= dividend[63] ^ divisor[31];
			num_q <= dividend[63] ? (~dividend + 64'd1) : dividend;
			den_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			rem_q <= '0;
		end else if (state_q == D_RUN) begin
			num_q <= {num_q[62:0], qbit};
			rem_q <= qbit ? diff[31:0] : trial[31:0];
		end
	end

endmodule

[rtl/core/puwc_back.sv]
`timescale 1ns / 1ps
// result side: weights and sums unwrapped atoms, divides on the last atom,
// holds the output beat; depends on puwc_pkg and puwc_div
module puwc_back import puwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] total_weight,
	input  logic               head_valid,
	input  puwc_atom_t         head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [191:0]       m_axis_tdata,  // unwrapped_x/y/z, center_x/y/z
	output logic               m_axis_tlast,  // center_valid
	output logic [1:0]         m_axis_tuser   // wrap_error, center_saturated
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_ACC  = 5'b00010,
		B_DST  = 5'b00100,
		B_DIV  = 5'b01000,
		B_OUT  = 5'b10000
	} back_state_t;

	back_state_t        state_q;
	puwc_atom_t         ent_s1;
	logic signed [63:0] prod_s1 [3];
	logic [63:0]        sum_q   [3];
	logic signed [31:0] cen_q   [3];
	logic               sat_q;
	logic [1:0]         axis_q;
	logic               load;

	logic               div_start;
	logic [63:0]        div_dividend;
	logic signed [31:0] div_divisor;
	logic               div_done;
	logic signed [31:0] div_quot;
	logic               div_sat;

	assign pop       = state_q == B_IDLE && head_valid;
	assign div_start = state_q == B_DST;
	assign load      = state_q == B_OUT && (!m_axis_tvalid || m_axis_tready);
	assign div_divisor = (total_weight == '0) ? WEIGHT_ONE : total_weight;

	always_comb begin
		unique case (axis_q)
			2'd0:    div_dividend = sum_q[0];
			2'd1:    div_dividend = sum_q[1];
			default: div_dividend = sum_q[2];
		endcase
	end

	puwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.sat      (div_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			axis_q        <= '0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (head_valid) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					for (int i = 0; i < 3; i++) begin
						sum_q[i] <= sum_q[i] + prod_s1[i];
					end
					axis_q  <= '0;
					state_q <= ent_s1.last ? B_DST : B_OUT;
				end
				B_DST: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (div_done) begin
						if (axis_q == 2'd2) begin
							state_q <= B_OUT;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= B_DST;
						end
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_IDLE;
						if (ent_s1.last) begin
							for (int i = 0; i < 3; i++) begin
								sum_q[i] <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1     <= head;
			prod_s1[0] <= head.px * head.w;
			prod_s1[1] <= head.py * head.w;
			prod_s1[2] <= head.pz * head.w;
			sat_q      <= 1'b0;
		end else if (state_q == B_DIV && div_done) begin
			cen_q[axis_q] <= div_quot;
			sat_q         <= sat_q | div_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata[95:0] <= {ent_s1.pz, ent_s1.py, ent_s1.px};
			if (ent_s1.last) begin
				m_axis_tdata[191:96] <= {cen_q[2], cen_q[1], cen_q[0]};
			end else begin
				m_axis_tdata[191:96] <= '0;
			end
			m_axis_tlast    <= ent_s1.last;
			m_axis_tuser[0] <= ent_s1.err;
			m_axis_tuser[1] <= ent_s1.last & sat_q;
		end
	end

	a_centre_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[191:96] == '0 && !m_axis_tuser[1])
		else $error("centre fields set on a beat that closes no molecule");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == B_DIV)
		else $error("divider finished outside the divide phase");

endmodule

[rtl/core/periodic_unwrap_weighted_center.sv]
`timescale 1ns / 1ps
// Periodic unwrap and weighted centre of a molecule, one atom per input beat.
// Channels: s_axis carries atom_x/y/z and atom_weight in tdata with last_atom
// in tlast; m_axis returns one beat per atom with the unwrapped position and,
// on the last atom, the centre in tdata, center_valid in tlast, wrap_error and
// center_saturated in tuser. cfg writes box_x/y/z and total_weight by index
// and must only be used while no atom is in flight.
// Path: an ordinary atom's result beat passes the input stage, the queue,
// the product register and the accumulate and output states of the back
// side; a last atom adds three divisions (load, 64 quotient steps, finish)
// in the shared divider. The back side takes one atom at a time and pops the
// next only after loading the output beat; the input keeps accepting into a
// four-entry queue while the back side divides or waits.
// Reset: boxes and total_weight go to 1.0 (Q16.16), sums clear and the next
// atom starts a molecule. When m_axis stalls the output beat is held, the
// queue fills and s_axis tready drops once it and the input stage are full.
// Depends on puwc_pkg, puwc_front, puwc_fifo, puwc_div and puwc_back.
module periodic_unwrap_weighted_center import puwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [127:0]         s_axis_tdata,  // atom_x, atom_y, atom_z, atom_weight
	input  logic                 s_axis_tlast,  // last_atom
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [191:0]         m_axis_tdata,  // unwrapped_x/y/z, center_x/y/z
	output logic                 m_axis_tlast,  // center_valid
	output logic [1:0]           m_axis_tuser,  // wrap_error, center_saturated
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	puwc_box_t          box_q;
	logic signed [31:0] total_weight_q;
	logic               push;
	puwc_atom_t         push_data;
	logic               fifo_full;
	logic               fifo_not_empty;
	puwc_atom_t         fifo_head;
	logic               pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.box_x    <= 31'd65536;
			box_q.box_y    <= 31'd65536;
			box_q.box_z    <= 31'd65536;
			total_weight_q <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_X:        box_q.box_x    <= cfg_data[30:0];
				REG_BOX_Y:        box_q.box_y    <= cfg_data[30:0];
				REG_BOX_Z:        box_q.box_z    <= cfg_data[30:0];
				REG_TOTAL_WEIGHT: total_weight_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	puwc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.box           (box_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.fifo_full     (fifo_full),
		.push          (push),
		.push_data     (push_data)
	);

	puwc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (fifo_not_empty),
		.head      (fifo_head)
	);

	puwc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.total_weight  (total_weight_q),
		.head_valid    (fifo_not_empty),
		.head          (fifo_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
